[rtl/sssd_pkg.sv]
// Shared constants and segment encoding for the seven-segment serial driver.
package sssd_pkg;

    localparam int WORD_BITS           = 16;
    localparam int MAX_DIGITS          = 4;
    localparam int DIGIT_COUNT_DEFAULT = 4;
    localparam int VALUE_W             = 16;

    // Reciprocal multipliers: floor(v * MUL >> SHIFT) == v / divisor for any 16-bit v.
    localparam logic [16:0] DIV10_MUL     = 17'd52429;
    localparam int          DIV10_SHIFT   = 19;
    localparam logic [16:0] DIV100_MUL    = 17'd83887;
    localparam int          DIV100_SHIFT  = 23;
    localparam logic [16:0] DIV1000_MUL   = 17'd67109;
    localparam int          DIV1000_SHIFT = 26;

    // Small divide by ten for values below 128.
    localparam logic [7:0] DIV10_SMALL_MUL   = 8'd205;
    localparam int         DIV10_SMALL_SHIFT = 11;

    // Segments a..g then dp, segment a in bit 7, active high.
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'b1111_1100;
            4'd1:    pat = 8'b0110_0000;
            4'd2:    pat = 8'b1101_1010;
            4'd3:    pat = 8'b1111_0010;
            4'd4:    pat = 8'b0110_0110;
            4'd5:    pat = 8'b1011_0110;
            4'd6:    pat = 8'b1011_1110;
            4'd7:    pat = 8'b1110_0000;
            4'd8:    pat = 8'b1111_1110;
            4'd9:    pat = 8'b1111_0110;
            default: pat = 8'b0000_0000;
        endcase
        return pat;
    endfunction

    // Word for one digit: one-hot select in the top nibble, inverted segments below.
    function automatic logic [WORD_BITS-1:0] digit_word(input logic [1:0] pos,
                                                        input logic [3:0] digit);
        logic [3:0] sel;
        sel = 4'b1000 >> pos;
        return {sel, 4'b0000, ~seg_pattern(digit)};
    endfunction

endpackage

[rtl/seven_segment_serial_display_driver_core.sv]
// Seven-segment serial display driver: value to per-digit words, shifted out LSB first.
// Each value is registered as quotients, then its words load into the shift register when
// the serializer is idle or on its final bit; the serializer emits one bit per cycle while
// i_out_ready is high, and the next value is split while the current one shifts out.
// Reset (synchronous, active low) clears the stage valid flags and the bit counter.
module seven_segment_serial_display_driver_core #(
    parameter int DIGIT_COUNT = sssd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sssd_pkg::VALUE_W-1:0] i_display_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_serial_bit,
    output logic                         o_latch_after,
    output logic                         o_last_bit
);
    import sssd_pkg::*;

    localparam int DIGITS  = (DIGIT_COUNT < 1) ? 1 :
                             ((DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT);
    localparam int TOTAL   = WORD_BITS * DIGITS;
    localparam int CNT_W   = $clog2(TOTAL);
    localparam int PROD_W  = VALUE_W + 17;
    localparam int Q1_W    = 13;
    localparam int Q2_W    = 10;
    localparam int Q3_W    = 7;

    // Quotient stage
    logic              r_q_vld;
    logic [VALUE_W-1:0] r_v;
    logic [Q1_W-1:0]   r_q1;
    logic [Q2_W-1:0]   r_q2;
    logic [Q3_W-1:0]   r_q3;

    // Serializer
    logic              r_busy;
    logic [TOTAL-1:0]  r_shift;
    logic [CNT_W-1:0]  r_cnt;

    logic              n_q_vld;
    logic              n_busy;

    logic              in_xfer;
    logic              out_xfer;
    logic              at_last;
    logic              load;

    logic [PROD_W-1:0] prod10;
    logic [PROD_W-1:0] prod100;
    logic [PROD_W-1:0] prod1000;

    logic [3:0]        dig [MAX_DIGITS];
    logic [VALUE_W-1:0] units_base;
    logic [Q1_W-1:0]   tens_base;
    logic [Q2_W-1:0]   hund_base;
    logic [14:0]       q3_prod;
    logic [3:0]        q3_div;
    logic [Q3_W-1:0]   thou_base;
    logic [TOTAL-1:0]  packed_words;

    assign at_last  = (r_cnt == CNT_W'(TOTAL - 1));
    assign out_xfer = r_busy && i_out_ready;
    assign load     = r_q_vld && (!r_busy || (i_out_ready && at_last));
    assign in_xfer  = i_in_valid && o_in_ready;

    assign o_in_ready    = !r_q_vld || load;
    assign o_out_valid   = r_busy;
    assign o_serial_bit  = r_shift[0];
    assign o_latch_after = &r_cnt[3:0];
    assign o_last_bit    = at_last;

    // Quotients by reciprocal multiplication
    assign prod10   = PROD_W'(i_display_value) * PROD_W'(DIV10_MUL);
    assign prod100  = PROD_W'(i_display_value) * PROD_W'(DIV100_MUL);
    assign prod1000 = PROD_W'(i_display_value) * PROD_W'(DIV1000_MUL);

    // Digits from neighboring quotients; each remainder is below ten
    always_comb begin
        units_base = VALUE_W'({r_q1, 3'b000}) + VALUE_W'({r_q1, 1'b0});
        tens_base  = Q1_W'({r_q2, 3'b000}) + Q1_W'({r_q2, 1'b0});
        hund_base  = Q2_W'({r_q3, 3'b000}) + Q2_W'({r_q3, 1'b0});
        q3_prod    = 15'(r_q3) * 15'(DIV10_SMALL_MUL);
        q3_div     = 4'(q3_prod >> DIV10_SMALL_SHIFT);
        thou_base  = Q3_W'({q3_div, 3'b000}) + Q3_W'({q3_div, 1'b0});

        dig[0] = 4'(r_q3 - thou_base);
        dig[1] = 4'(r_q2 - hund_base);
        dig[2] = 4'(r_q1 - tens_base);
        dig[3] = 4'(r_v - units_base);
    end

    // Digit 0 occupies the low word so it shifts out first
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            packed_words[d*WORD_BITS +: WORD_BITS] = digit_word(2'(d), dig[d]);
        end
    end

    always_comb begin
        n_q_vld = r_q_vld;
        if (in_xfer) begin
            n_q_vld = 1'b1;
        end else if (load) begin
            n_q_vld = 1'b0;
        end

        n_busy = r_busy;
        if (load) begin
            n_busy = 1'b1;
        end else if (out_xfer && at_last) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_q_vld <= n_q_vld;
            r_busy  <= n_busy;
            if (load) begin
                r_cnt <= '0;
            end else if (out_xfer) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_v  <= i_display_value;
            r_q1 <= prod10[DIV10_SHIFT +: Q1_W];
            r_q2 <= prod100[DIV100_SHIFT +: Q2_W];
            r_q3 <= prod1000[DIV1000_SHIFT +: Q3_W];
        end
        if (load) begin
            r_shift <= packed_words;
        end else if (out_xfer) begin
            r_shift <= r_shift >> 1;
        end
    end

    // The final bit of a refresh is always a word end
    a_last_is_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_bit) |-> o_latch_after)
        else $error("last bit without latch strobe");

    // Backpressure only comes from a pending value
    a_ready_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_q_vld && r_busy))
        else $error("input stalled with nothing pending");

    // Drain ends the refresh when nothing is waiting
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && at_last && !r_q_vld) |=> !o_out_valid)
        else $error("output valid after final bit with no pending value");

    // Stalled output holds its position
    a_hold_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_out_ready) |=> $stable(r_cnt))
        else $error("bit counter moved during stall");

endmodule

[dv/seven_segment_serial_display_driver_core_tb.sv]
// Testbench for the seven-segment serial display driver: directed and random values, serial bits checked.
`timescale 1ns / 1ps

module seven_segment_serial_display_driver_core_tb;

    localparam int DIGITS         = sssd_pkg::DIGIT_COUNT_DEFAULT;
    localparam int BITS_PER_DIGIT = 16;
    localparam int IDLE_PCT       = 27;
    localparam int RANDOM_VALUES  = 130;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 20;

    // Lit segments per decimal digit, segment a in bit 7 and dp in bit 0.
    localparam logic [7:0] LIT_SEGMENTS [0:9] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    typedef struct packed {
        logic serial;
        logic latch;
        logic last;
    } t_shift_bit;

    class refresh_scoreboard;
        t_shift_bit expected_bits[$];
        int         values_seen;
        int         bits_checked;
        int         mismatches;

        function int digits_shown();
            if (DIGITS < 1) return 1;
            if (DIGITS > 4) return 4;
            return DIGITS;
        endfunction

        // Expand one accepted value into the bits of its refresh.
        function void note_value(logic [15:0] value);
            int         count;
            int         place;
            int         digit;
            logic [15:0] word;
            t_shift_bit b;
            count = digits_shown();
            for (int d = 0; d < count; d++) begin
                place = (d == 0) ? 1000 : (d == 1) ? 100 : (d == 2) ? 10 : 1;
                digit = (int'(value) / place) % 10;
                word  = (16'h8000 >> d) | {8'h00, ~LIT_SEGMENTS[digit]};
                for (int i = 0; i < BITS_PER_DIGIT; i++) begin
                    b.serial = word[i];
                    b.latch  = (i == BITS_PER_DIGIT - 1);
                    b.last   = (i == BITS_PER_DIGIT - 1) && (d == count - 1);
                    expected_bits.push_back(b);
                end
            end
            values_seen++;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] %s", $time, what);
        endfunction

        function void check_bit(logic serial, logic latch, logic last);
            t_shift_bit exp_bit;
            t_shift_bit got_bit;
            got_bit = '{serial, latch, last};
            if (expected_bits.size() == 0) begin
                report($sformatf("unexpected bit serial=%b latch=%b last=%b",
                                 serial, latch, last));
                return;
            end
            exp_bit = expected_bits.pop_front();
            if (got_bit !== exp_bit)
                report($sformatf("bit %0d: expected serial=%b latch=%b last=%b, got %b %b %b",
                                 bits_checked, exp_bit.serial, exp_bit.latch, exp_bit.last,
                                 serial, latch, last));
            bits_checked++;
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction

        function void final_check();
            if (expected_bits.size() != 0)
                report($sformatf("%0d expected bits never arrived", expected_bits.size()));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_display_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_serial_bit;
    logic        o_latch_after;
    logic        o_last_bit;

    refresh_scoreboard sb = new();
    bit                steady;
    bit                hold_done;
    int                hold_left;
    int                quiet_cycles;
    int                directed_count;

    seven_segment_serial_display_driver_core #(
        .DIGIT_COUNT(DIGITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_display_value(i_display_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_serial_bit   (o_serial_bit),
        .o_latch_after  (o_latch_after),
        .o_last_bit     (o_last_bit)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one value; called at a falling edge, returns at a falling edge.
    task automatic send_value(input logic [15:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_display_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_value(value);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] random_value();
        case ($urandom_range(0, 3))
            0, 1: return 16'($urandom_range(0, 65535));
            2:    return 16'($urandom_range(0, 9999));
            default: return 16'($urandom_range(10000, 65535));
        endcase
    endfunction

    // Receiver: check at the rising edge, pick ready at the falling edge.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_bit(o_serial_bit, o_latch_after, o_last_bit);
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && sb.values_seen >= 90) begin
                // Hold off long enough for the block to back up into its input.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [15:0] directed[$];
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_display_value = 16'h0000;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Field extremes, every digit in every place, values past 9999.
        directed = '{16'd0, 16'd65535, 16'd9999, 16'd10000, 16'd1234, 16'd5678,
                     16'h5555, 16'hAAAA, 16'h8000, 16'd1, 16'd59999, 16'd40000};
        for (int k = 1; k <= 9; k++) directed.push_back(16'(1111 * k));
        foreach (directed[n]) send_value(directed[n]);
        directed_count = directed.size();

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            steady = (n >= 20 && n < 60);
            send_value(random_value());
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.final_check();

        $display("Sent %0d values (%0d directed, %0d random), checked %0d serial bits,",
                 sb.values_seen, directed_count, sb.values_seen - directed_count,
                 sb.bits_checked);
        $display("including a %0d-cycle output hold-off; %0d mismatches in total.",
                 HOLD_CYCLES, sb.mismatches);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/sssd_pkg.sv
rtl/seven_segment_serial_display_driver_core.sv
dv/seven_segment_serial_display_driver_core_tb.sv
